>>> rtl/core/imuffe_pkg.sv
// Package for the IMU frame field extractor.
// Request/response payload types, frame layout constants and codes.
// No dependencies.
package imuffe_pkg;

   localparam int FRAME_BYTES_DEFAULT = 82;
   localparam int POS_W               = 7;
   localparam int NUM_WORDS           = 6;
   localparam int WORD_W              = 32;
   localparam int WIDX_W              = 3;

   localparam logic [7:0] SYNC_A    = 8'h5A;
   localparam logic [7:0] SYNC_B    = 8'hA5;
   localparam logic [7:0] TAG_RESET = 8'h91;

   localparam logic [POS_W-1:0] POS_SYNC_A = 7'd0;
   localparam logic [POS_W-1:0] POS_SYNC_B = 7'd1;
   localparam logic [POS_W-1:0] POS_TYPE   = 7'd6;

   // frame position of byte 0 of each captured word: header length plus payload offset
   localparam logic [POS_W-1:0] WORD_START [NUM_WORDS] = '{
      7'd30, 7'd34, 7'd38, 7'd54, 7'd58, 7'd62
   };

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_IDLE = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [31:0] roll_rate_bits;
      logic [31:0] pitch_rate_bits;
      logic [31:0] yaw_rate_bits;
      logic [31:0] pitch_angle_bits;
      logic [31:0] roll_angle_bits;
      logic [31:0] yaw_angle_bits;
   } rsp_type;

endpackage

>>> rtl/core/imuffe_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module imuffe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 12
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/imu_frame_field_extractor.sv
// IMU serial frame field extractor, top level.
// Depends on imuffe_pkg and imuffe_ram.
//
// Usage:
//   req channel carries one received serial byte (kind = byte) or a line
//   idle event (kind = idle) per request. Bytes are counted from the start
//   of a burst; only the first FRAME_BYTES are kept. The idle event closes
//   the burst and yields exactly one response on the rsp channel.
//   rsp carries the accepted flag (sync 5A A5 and packet tag matched) and
//   six raw float32 words; all words read zero unless accepted, and bytes
//   that never arrived read as zero.
//   csr_write_enable / csr_write_data set the expected packet tag (reset 0x91).
// Throughput and readout:
//   Byte requests are taken every cycle, always, including while a response
//   waits. Each byte inside a word window is merged into an assembly register
//   and written to the word RAM (two banks of six, one per burst in flight).
//   An idle request starts a readout that issues one RAM read per word; the
//   response shows once the last word is captured. A further idle request
//   waits (req_ready low for it) until the previous response is taken.
// Reset: synchronous, active high; clears position, header captures, word
//   valid bits and the readout; the tag returns to 0x91. No clearing pass.
module imu_frame_field_extractor #(
   parameter int FRAME_BYTES = imuffe_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  imuffe_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output imuffe_pkg::rsp_type rsp_data,
   input  logic                csr_write_enable,
   input  logic [7:0]          csr_write_data
);

   localparam int NW        = imuffe_pkg::NUM_WORDS;
   localparam int RAM_DEPTH = 2 * NW;
   localparam int ADDR_W    = $clog2(RAM_DEPTH);
   localparam logic [imuffe_pkg::POS_W-1:0] POS_LIMIT = imuffe_pkg::POS_W'(FRAME_BYTES);
   localparam logic [imuffe_pkg::WIDX_W-1:0] LAST_WORD = imuffe_pkg::WIDX_W'(NW - 1);
   localparam logic [imuffe_pkg::WIDX_W-1:0] NUM_WIDX  = imuffe_pkg::WIDX_W'(NW);

   logic [imuffe_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [7:0] sync_a_ff, sync_a_in, sync_b_ff, sync_b_in, type_ff, type_in;
   logic [7:0] tag_ff, tag_in;
   logic [31:0] asm_ff, asm_in;
   logic        wr_bank_ff, wr_bank_in;
   logic [NW-1:0] vmask_ff, vmask_in;

   logic        rd_busy_ff, rd_busy_in;
   logic [imuffe_pkg::WIDX_W-1:0] rd_issue_ff, rd_issue_in;
   logic        rd_bank_ff, rd_bank_in;
   logic        rd_ok_ff, rd_ok_in;
   logic [NW-1:0] rd_mask_ff, rd_mask_in;
   logic        rdv_ff, rdv_in;
   logic [imuffe_pkg::WIDX_W-1:0] rds_ff, rds_in;
   logic [31:0] words_ff [NW];
   logic [31:0] words_in [NW];
   logic        rsp_valid_ff, rsp_valid_in;

   logic        byte_acc, idle_acc, rsp_acc, keep, hit;
   logic [imuffe_pkg::WIDX_W-1:0] hit_k;
   logic [1:0]  lane;
   logic [31:0] merged;
   logic        ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [31:0] ram_rdata;

   assign req_ready = !(req_data.kind == imuffe_pkg::KIND_IDLE && rd_busy_ff);
   assign byte_acc  = req_valid && req_ready && req_data.kind == imuffe_pkg::KIND_BYTE;
   assign idle_acc  = req_valid && req_ready && req_data.kind == imuffe_pkg::KIND_IDLE;
   assign rsp_acc   = rsp_valid_ff && rsp_ready;
   assign keep      = pos_ff < POS_LIMIT;

   // locate the word window (if any) the current position falls in
   always_comb begin
      hit   = 1'b0;
      hit_k = '0;
      lane  = '0;
      for (int k = 0; k < NW; k++) begin
         if (pos_ff >= imuffe_pkg::WORD_START[k] &&
             pos_ff < imuffe_pkg::WORD_START[k] + 7'd4) begin
            hit   = 1'b1;
            hit_k = imuffe_pkg::WIDX_W'(k);
            lane  = 2'(pos_ff - imuffe_pkg::WORD_START[k]);
         end
      end
   end

   // lane 0 starts a fresh word, so the assembly register needs no clear
   assign merged = (lane == 2'd0) ? {24'd0, req_data.rx_byte}
                                  : (asm_ff | (32'(req_data.rx_byte) << {lane, 3'b000}));

   assign ram_we    = byte_acc && keep && hit;
   assign ram_waddr = wr_bank_ff ? ADDR_W'(NUM_WIDX) + ADDR_W'(hit_k) : ADDR_W'(hit_k);
   assign ram_raddr = rd_bank_ff ? ADDR_W'(NUM_WIDX) + ADDR_W'(rd_issue_ff)
                                 : ADDR_W'(rd_issue_ff);

   imuffe_ram #(
      .WIDTH (imuffe_pkg::WORD_W),
      .DEPTH (RAM_DEPTH)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (merged),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      pos_in       = pos_ff;
      sync_a_in    = sync_a_ff;
      sync_b_in    = sync_b_ff;
      type_in      = type_ff;
      tag_in       = csr_write_enable ? csr_write_data : tag_ff;
      asm_in       = ram_we ? merged : asm_ff;
      wr_bank_in   = wr_bank_ff;
      vmask_in     = vmask_ff;
      rd_busy_in   = rd_busy_ff;
      rd_issue_in  = rd_issue_ff;
      rd_bank_in   = rd_bank_ff;
      rd_ok_in     = rd_ok_ff;
      rd_mask_in   = rd_mask_ff;
      rdv_in       = 1'b0;
      rds_in       = rd_issue_ff;
      rsp_valid_in = rsp_valid_ff;
      words_in     = words_ff;

      if (byte_acc && keep) begin
         pos_in = pos_ff + 7'd1;
         if (pos_ff == imuffe_pkg::POS_SYNC_A) sync_a_in = req_data.rx_byte;
         if (pos_ff == imuffe_pkg::POS_SYNC_B) sync_b_in = req_data.rx_byte;
         if (pos_ff == imuffe_pkg::POS_TYPE)   type_in   = req_data.rx_byte;
         if (hit) vmask_in[hit_k] = 1'b1;
      end

      if (idle_acc) begin
         rd_ok_in    = sync_a_ff == imuffe_pkg::SYNC_A && sync_b_ff == imuffe_pkg::SYNC_B &&
                       type_ff == tag_ff;
         rd_mask_in  = vmask_ff;
         rd_bank_in  = wr_bank_ff;
         rd_busy_in  = 1'b1;
         rd_issue_in = '0;
         wr_bank_in  = !wr_bank_ff;
         vmask_in    = '0;
         pos_in      = '0;
         sync_a_in   = '0;
         sync_b_in   = '0;
         type_in     = '0;
      end else if (rd_busy_ff && rd_issue_ff < NUM_WIDX) begin
         rdv_in      = 1'b1;
         rd_issue_in = rd_issue_ff + 3'd1;
      end

      if (rdv_ff) begin
         words_in[rds_ff] = (rd_ok_ff && rd_mask_ff[rds_ff]) ? ram_rdata : 32'd0;
         if (rds_ff == LAST_WORD) rsp_valid_in = 1'b1;
      end

      if (rsp_acc) begin
         rsp_valid_in = 1'b0;
         rd_busy_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         sync_a_ff    <= '0;
         sync_b_ff    <= '0;
         type_ff      <= '0;
         tag_ff       <= imuffe_pkg::TAG_RESET;
         wr_bank_ff   <= 1'b0;
         vmask_ff     <= '0;
         rd_busy_ff   <= 1'b0;
         rd_issue_ff  <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         sync_a_ff    <= sync_a_in;
         sync_b_ff    <= sync_b_in;
         type_ff      <= type_in;
         tag_ff       <= tag_in;
         wr_bank_ff   <= wr_bank_in;
         vmask_ff     <= vmask_in;
         rd_busy_ff   <= rd_busy_in;
         rd_issue_ff  <= rd_issue_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      asm_ff     <= asm_in;
      rd_bank_ff <= rd_bank_in;
      rd_ok_ff   <= rd_ok_in;
      rd_mask_ff <= rd_mask_in;
      rds_ff     <= rds_in;
      words_ff   <= words_in;
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_data.accepted         = rd_ok_ff;
   assign rsp_data.roll_rate_bits   = words_ff[0];
   assign rsp_data.pitch_rate_bits  = words_ff[1];
   assign rsp_data.yaw_rate_bits    = words_ff[2];
   assign rsp_data.pitch_angle_bits = words_ff[3];
   assign rsp_data.roll_angle_bits  = words_ff[4];
   assign rsp_data.yaw_angle_bits   = words_ff[5];

endmodule

>>> rtl/core/imuffe_checker.sv
// Port-level checks for the IMU frame field extractor, bound to the top level.
// Depends on imuffe_pkg.
module imuffe_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input imuffe_pkg::req_type req_data,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input imuffe_pkg::rsp_type rsp_data
);

   logic idle_req;
   assign idle_req = req_valid && req_ready && req_data.kind == imuffe_pkg::KIND_IDLE;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.accepted |->
         rsp_data.roll_rate_bits == 32'd0 && rsp_data.pitch_rate_bits == 32'd0 &&
         rsp_data.yaw_rate_bits == 32'd0 && rsp_data.pitch_angle_bits == 32'd0 &&
         rsp_data.roll_angle_bits == 32'd0 && rsp_data.yaw_angle_bits == 32'd0)
      else $error("rejected frame carries nonzero words");

   a_idle_gap: assert property (@(posedge clock) disable iff (reset)
      idle_req |-> !rsp_valid ##1 !rsp_valid)
      else $error("idle request taken while a response is pending");

   a_idle_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && req_valid && req_data.kind == imuffe_pkg::KIND_IDLE |-> !req_ready)
      else $error("idle request accepted over an untaken response");

endmodule

bind imu_frame_field_extractor imuffe_checker u_imuffe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
